// ===== hw/rtl/uhcg_pkg.sv =====
// Shared types, constants and checksum helpers for the UDP header checksum generator.
`timescale 1ns / 1ps

package uhcg_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSrcAddrHigh = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcAddrLow  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgDstAddrHigh = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDstAddrLow  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSrcPort     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDstPort     = 3'd5;

  localparam logic [WordW-1:0]  UdpProto    = 16'd17;
  localparam logic [WordW-1:0]  UdpHdrBytes = 16'd8;
  localparam logic [CountW-1:0] MaxPayload  = 17'd65527;

  // Snapshot of a finished packet, handed from the accumulator to the finisher.
  typedef struct packed {
    logic              valid;
    logic [WordW-1:0]  sum;
    logic [CountW-1:0] count;
  } snap_t;

  // Per-packet constant part of the header and of the checksum.
  typedef struct packed {
    logic [WordW-1:0] sport;
    logic [WordW-1:0] dport;
    logic [WordW-1:0] sum;
  } cfg_t;

  // Fold a sum of at most twenty bits into a 16-bit ones'-complement value.
  // Zero stays zero, and any nonzero sum lands in 1..0xFFFF.
  function automatic logic [WordW-1:0] fold_sum(input logic [19:0] t);
    logic [16:0] t1;
    logic [16:0] t2;
    t1 = {1'b0, t[15:0]} + {13'd0, t[19:16]};
    t2 = {1'b0, t1[15:0]} + {16'd0, t1[16]};
    return t2[15:0];
  endfunction

  // End-around-carry add of two 16-bit words.
  function automatic logic [WordW-1:0] add_word(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    return fold_sum({4'd0, a} + {4'd0, b});
  endfunction

  // Folded sum of the four 16-bit words of a 64-bit register.
  function automatic logic [WordW-1:0] quad_sum(input logic [CfgDataW-1:0] v);
    return fold_sum({4'd0, v[63:48]} + {4'd0, v[47:32]} +
                    {4'd0, v[31:16]} + {4'd0, v[15:0]});
  endfunction

endpackage

// ===== hw/rtl/uhcg_cfg.sv =====
// Configuration registers with the pre-folded constant part of the checksum.
`timescale 1ns / 1ps

module uhcg_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uhcg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uhcg_pkg::CfgDataW-1:0]  cfg_data_i,
  output uhcg_pkg::cfg_t                 cfg_o
);

  logic [uhcg_pkg::WordW-1:0] src_hi_q, src_lo_q, dst_hi_q, dst_lo_q;
  logic [uhcg_pkg::WordW-1:0] sport_q, dport_q;
  logic [uhcg_pkg::WordW-1:0] cfg_sum_d, cfg_sum_q;
  logic [uhcg_pkg::WordW-1:0] wr_quad;

  assign cfg_ready_o = 1'b1;
  assign wr_quad     = uhcg_pkg::quad_sum(cfg_data_i);

  // Addresses are kept only as their folded word sums; nothing else reads them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_hi_q <= '0;
      src_lo_q <= '0;
      dst_hi_q <= '0;
      dst_lo_q <= '0;
      sport_q  <= '0;
      dport_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        uhcg_pkg::CfgSrcAddrHigh: src_hi_q <= wr_quad;
        uhcg_pkg::CfgSrcAddrLow:  src_lo_q <= wr_quad;
        uhcg_pkg::CfgDstAddrHigh: dst_hi_q <= wr_quad;
        uhcg_pkg::CfgDstAddrLow:  dst_lo_q <= wr_quad;
        uhcg_pkg::CfgSrcPort:     sport_q  <= cfg_data_i[15:0];
        uhcg_pkg::CfgDstPort:     dport_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_sum_d = uhcg_pkg::fold_sum({4'd0, src_hi_q} + {4'd0, src_lo_q} +
                                        {4'd0, dst_hi_q} + {4'd0, dst_lo_q} +
                                        {4'd0, sport_q} + {4'd0, dport_q} +
                                        {4'd0, uhcg_pkg::UdpProto});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_sum_q <= uhcg_pkg::UdpProto;
    end else begin
      cfg_sum_q <= cfg_sum_d;
    end
  end

  assign cfg_o.sport = sport_q;
  assign cfg_o.dport = dport_q;
  assign cfg_o.sum   = cfg_sum_q;

endmodule

// ===== hw/rtl/uhcg_accum.sv =====
// Input register and running payload sum and byte count.
`timescale 1ns / 1ps

module uhcg_accum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [15:0]                 payload_word_i,
  input  logic [1:0]                  word_bytes_i,
  input  logic                        word_last_i,
  input  logic                        snap_ready_i,
  output uhcg_pkg::snap_t             snap_o
);

  logic                          in_valid_q;
  logic [15:0]                   word_q;
  logic [1:0]                    bytes_q;
  logic                          last_q;
  logic                          fire;
  logic                          fire_last;
  logic [1:0]                    nbytes;
  logic [15:0]                   word_m;
  logic [17:0]                   total;
  logic [uhcg_pkg::WordW-1:0]    sum_new, sum_d, sum_q;
  logic [uhcg_pkg::CountW-1:0]   count_new, count_d, count_q;
  logic                          snap_valid_q;
  logic [uhcg_pkg::WordW-1:0]    snap_sum_q;
  logic [uhcg_pkg::CountW-1:0]   snap_count_q;

  // Only a last word can be held up, and only by a full snapshot slot.
  assign in_stall_o = in_valid_q && last_q && !snap_ready_i;
  assign fire       = in_valid_q && !in_stall_o;
  assign fire_last  = fire && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      word_q  <= payload_word_i;
      bytes_q <= word_bytes_i;
      last_q  <= word_last_i;
    end
  end

  always_comb begin
    nbytes  = (bytes_q == 2'd3) ? 2'd2 : bytes_q;
    word_m  = (nbytes == 2'd1) ? {word_q[15:8], 8'h00} : word_q;
    total   = {1'b0, count_q} + {16'd0, nbytes};
    sum_new   = sum_q;
    count_new = count_q;
    if (nbytes != 2'd0) begin
      sum_new   = uhcg_pkg::add_word(sum_q, word_m);
      count_new = total[17] ? '1 : total[16:0];
    end
    sum_d   = sum_q;
    count_d = count_q;
    if (fire) begin
      sum_d   = last_q ? '0 : sum_new;
      count_d = last_q ? '0 : count_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (snap_ready_i) begin
      snap_valid_q <= fire_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_last) begin
      snap_sum_q   <= sum_new;
      snap_count_q <= count_new;
    end
  end

  assign snap_o.valid = snap_valid_q;
  assign snap_o.sum   = snap_sum_q;
  assign snap_o.count = snap_count_q;

endmodule

// ===== hw/rtl/uhcg_finish.sv =====
// Pseudo-header completion, length field and the output register.
`timescale 1ns / 1ps

module uhcg_finish (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  uhcg_pkg::snap_t   snap_i,
  input  uhcg_pkg::cfg_t    cfg_i,
  output logic              snap_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [15:0]       hdr_src_port_o,
  output logic [15:0]       hdr_dst_port_o,
  output logic [15:0]       hdr_length_o,
  output logic [15:0]       hdr_checksum_o,
  output logic              too_long_o
);

  logic        out_adv;
  logic        out_valid_q;
  logic        too_long;
  logic [15:0] len;
  logic [15:0] sum;
  logic [15:0] sport_q, dport_q, length_q, checksum_q;
  logic        too_long_q;

  assign out_adv      = !out_valid_q || !out_stall_i;
  assign snap_ready_o = !snap_i.valid || out_adv;

  // The length enters the sum twice: once as the pseudo-header length and
  // once as the UDP length field. Its upper pseudo-header word is zero.
  always_comb begin
    too_long = snap_i.count > uhcg_pkg::MaxPayload;
    len      = too_long ? 16'hFFFF : (snap_i.count[15:0] + uhcg_pkg::UdpHdrBytes);
    sum      = uhcg_pkg::fold_sum({4'd0, snap_i.sum} + {4'd0, cfg_i.sum} +
                                  {4'd0, len} + {4'd0, len});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= snap_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && snap_i.valid) begin
      sport_q    <= cfg_i.sport;
      dport_q    <= cfg_i.dport;
      length_q   <= len;
      checksum_q <= ~sum;
      too_long_q <= too_long;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hdr_src_port_o = sport_q;
  assign hdr_dst_port_o = dport_q;
  assign hdr_length_o   = length_q;
  assign hdr_checksum_o = checksum_q;
  assign too_long_o     = too_long_q;

endmodule

// ===== hw/rtl/udp_header_checksum_gen_core.sv =====
// Top level of the transmit-side UDP header builder with pseudo-header checksum.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Word carried
//  -------   ---------  -------------------  ------------------------------------------
//  in        sink       in_valid_i/in_stall_o  payload_word, word_bytes, word_last
//  out       source     out_valid_o/out_stall_i hdr ports, length, checksum, too_long
//  cfg       sink       cfg_valid_i/cfg_ready_o register index and 64-bit write data
//
//  One payload word is accepted every cycle while no last word is stalled.
//  The header word of a packet passes from the input register through the
//  snapshot register to the output register, where it is held until taken.
//  The rate is set by the combinational end-around-carry add
//  that updates the running sum. Reset clears the running state, the pipeline
//  valids and the configuration registers; the constant checksum term resets
//  to the protocol number, and the data registers of the pipeline are not
//  reset. A stall on the output holds the header word, then fills the
//  snapshot slot, and only then stalls a last payload word; words that are
//  not last keep flowing while a header waits.
//
// The design has three parts. The configuration block keeps each address
// register as its folded word sum and adds ports and the protocol into one
// constant checksum term, registered once more so the finisher sees it in the
// cycle after a write reaches its register. The accumulator registers each
// input word, masks a single-byte word, adds it into the running sum and
// counts its bytes; on a last word it hands a snapshot forward and clears
// its state. The finisher adds the constant term and twice the length,
// folds and complements the result and holds it in the output register.

module udp_header_checksum_gen_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Payload channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [15:0]                    payload_word_i,
  input  logic [1:0]                     word_bytes_i,
  input  logic                           word_last_i,
  // Header channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    hdr_src_port_o,
  output logic [15:0]                    hdr_dst_port_o,
  output logic [15:0]                    hdr_length_o,
  output logic [15:0]                    hdr_checksum_o,
  output logic                           too_long_o,
  // Configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [uhcg_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [uhcg_pkg::CfgDataW-1:0]  cfg_data_i
);

  uhcg_pkg::cfg_t  cfg;
  uhcg_pkg::snap_t snap;
  logic            snap_ready;

  uhcg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  uhcg_accum u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_word_i (payload_word_i),
    .word_bytes_i   (word_bytes_i),
    .word_last_i    (word_last_i),
    .snap_ready_i   (snap_ready),
    .snap_o         (snap)
  );

  uhcg_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .snap_i         (snap),
    .cfg_i          (cfg),
    .snap_ready_o   (snap_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hdr_src_port_o (hdr_src_port_o),
    .hdr_dst_port_o (hdr_dst_port_o),
    .hdr_length_o   (hdr_length_o),
    .hdr_checksum_o (hdr_checksum_o),
    .too_long_o     (too_long_o)
  );

  // The input side stalls only when both the snapshot and the output are full.
  a_stall_needs_full_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (snap.valid && out_valid_o && out_stall_i))
    else $error("input stalled while the output could move");

  // A snapshot that cannot move on keeps its contents.
  a_snap_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (snap.valid && !snap_ready) |=> (snap.valid && $stable(snap.sum) &&
                                      $stable(snap.count)))
    else $error("packet snapshot lost while blocked");

  // An oversize packet always reports the saturated length.
  a_too_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && too_long_o) |-> (hdr_length_o == 16'hFFFF))
    else $error("oversize packet without saturated length");

  // A normal packet length always includes the eight header bytes.
  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !too_long_o) |-> (hdr_length_o >= 16'd8))
    else $error("header length below header size");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the UDP header checksum generator core.
`timescale 1ns / 1ps

// Predicts one UDP header word per packet from the accepted payload words and
// compares each delivered header word with the oldest prediction.
class udp_hdr_scoreboard;

  typedef struct {
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] length;
    logic [15:0] checksum;
    logic        too_long;
  } hdr_t;

  hdr_t        pending_hdrs[$];
  logic [63:0] src_hi, src_lo, dst_hi, dst_lo;
  logic [15:0] sport, dport;
  logic [15:0] acc_sum;
  logic [16:0] acc_bytes;
  int unsigned fails;
  int unsigned hdr_count;

  function new();
    src_hi    = '0;
    src_lo    = '0;
    dst_hi    = '0;
    dst_lo    = '0;
    sport     = '0;
    dport     = '0;
    acc_sum   = '0;
    acc_bytes = '0;
    fails     = 0;
    hdr_count = 0;
  endfunction

  // End-around-carry add; the carry can never ripple out a second time.
  function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function logic [15:0] add_addr(logic [15:0] s, logic [63:0] v);
    s = ones_add(s, v[63:48]);
    s = ones_add(s, v[47:32]);
    s = ones_add(s, v[31:16]);
    return ones_add(s, v[15:0]);
  endfunction

  function void set_reg(logic [uhcg_pkg::CfgIdxW-1:0] idx, logic [63:0] data);
    case (idx)
      uhcg_pkg::CfgSrcAddrHigh: src_hi = data;
      uhcg_pkg::CfgSrcAddrLow:  src_lo = data;
      uhcg_pkg::CfgDstAddrHigh: dst_hi = data;
      uhcg_pkg::CfgDstAddrLow:  dst_lo = data;
      uhcg_pkg::CfgSrcPort:     sport = data[15:0];
      uhcg_pkg::CfgDstPort:     dport = data[15:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return pending_hdrs.size();
  endfunction

  // Called for every accepted payload word.
  function void note_word(logic [15:0] w, logic [1:0] nb, logic last);
    logic [15:0] word;
    logic [1:0]  n;
    logic [17:0] total;
    logic [15:0] s;
    logic [15:0] len;
    logic        tl;
    hdr_t        h;
    word = w;
    n    = nb;
    // A count of three means a full word; a single byte drops its low half.
    if (n == 2'd3) n = 2'd2;
    if (n == 2'd1) word[7:0] = 8'h00;
    if (n != 2'd0) begin
      acc_sum   = ones_add(acc_sum, word);
      total     = {1'b0, acc_bytes} + {16'd0, n};
      acc_bytes = (total > 18'h1FFFF) ? 17'h1FFFF : total[16:0];
    end
    if (!last) return;
    tl  = acc_bytes > uhcg_pkg::MaxPayload;
    len = tl ? 16'hFFFF : acc_bytes[15:0] + uhcg_pkg::UdpHdrBytes;
    s = acc_sum;
    s = add_addr(s, src_hi);
    s = add_addr(s, src_lo);
    s = add_addr(s, dst_hi);
    s = add_addr(s, dst_lo);
    s = ones_add(s, 16'h0000);
    s = ones_add(s, len);
    s = ones_add(s, uhcg_pkg::UdpProto);
    s = ones_add(s, sport);
    s = ones_add(s, dport);
    s = ones_add(s, len);
    h.sport    = sport;
    h.dport    = dport;
    h.length   = len;
    h.checksum = ~s;
    h.too_long = tl;
    pending_hdrs.push_back(h);
    acc_sum   = '0;
    acc_bytes = '0;
  endfunction

  function void cmp_field(string name, logic [15:0] exp, logic [15:0] act);
    if (act !== exp) begin
      $error("%s: expected %h, got %h", name, exp, act);
      fails++;
    end
  endfunction

  // Called for every accepted header word.
  function void check_header(logic [15:0] sp, logic [15:0] dp, logic [15:0] len,
                             logic [15:0] csum, logic tl);
    hdr_t e;
    if (pending_hdrs.size() == 0) begin
      $error("header word arrived with no packet outstanding");
      fails++;
      return;
    end
    e = pending_hdrs.pop_front();
    hdr_count++;
    cmp_field("hdr_src_port", e.sport, sp);
    cmp_field("hdr_dst_port", e.dport, dp);
    cmp_field("hdr_length", e.length, len);
    cmp_field("hdr_checksum", e.checksum, csum);
    cmp_field("too_long", {15'd0, e.too_long}, {15'd0, tl});
  endfunction

endclass

module tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [15:0]                   payload_word_i = '0;
  logic [1:0]                    word_bytes_i = '0;
  logic                          word_last_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [15:0]                   hdr_src_port_o;
  logic [15:0]                   hdr_dst_port_o;
  logic [15:0]                   hdr_length_o;
  logic [15:0]                   hdr_checksum_o;
  logic                          too_long_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [uhcg_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [uhcg_pkg::CfgDataW-1:0] cfg_data_i = '0;

  udp_hdr_scoreboard sb;

  // Idle controls shared by the payload driver and the header sink. A quiet
  // side never inserts gaps; the long hold request makes the sink stall for
  // a long stretch once, so the core backs up into its input.
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned rand_items = 0;

  udp_header_checksum_gen_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_word_i (payload_word_i),
    .word_bytes_i   (word_bytes_i),
    .word_last_i    (word_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hdr_src_port_o (hdr_src_port_o),
    .hdr_dst_port_o (hdr_dst_port_o),
    .hdr_length_o   (hdr_length_o),
    .hdr_checksum_o (hdr_checksum_o),
    .too_long_o     (too_long_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Offer one payload word and return at the edge that accepts it. Valid is
  // only dropped when a gap is drawn, so back-to-back words keep it high
  // without a second assignment in the same step.
  task automatic push_word(input logic [15:0] w, input logic [1:0] nb, input logic last);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    payload_word_i <= w;
    word_bytes_i   <= nb;
    word_last_i    <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w, nb, last);
  endtask

  // Mostly well-formed packets: full words, then a last word of one or two
  // bytes. About one word in ten gets an arbitrary byte count instead, which
  // covers zero and three counts and single bytes in mid-packet.
  task automatic send_rand_packet();
    int unsigned n;
    int unsigned k;
    logic [1:0]  nb;
    logic [15:0] w;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (k = 1; k <= n; k++) begin
      w = 16'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        nb = 2'($urandom_range(0, 3));
      end else if (k == n) begin
        nb = 2'($urandom_range(1, 2));
      end else begin
        nb = 2'd2;
      end
      push_word(w, nb, k == n);
      rand_items++;
    end
  endtask

  // Stop offering words, wait for every outstanding header, then give the
  // pipeline time to show any stray header word.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [uhcg_pkg::CfgIdxW-1:0] idx, input logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Writes all six registers back to back; only called while the core is idle.
  task automatic write_config(input logic [63:0] sah, input logic [63:0] sal,
                              input logic [63:0] dah, input logic [63:0] dal,
                              input logic [63:0] sp, input logic [63:0] dp);
    write_reg(uhcg_pkg::CfgSrcAddrHigh, sah);
    write_reg(uhcg_pkg::CfgSrcAddrLow, sal);
    write_reg(uhcg_pkg::CfgDstAddrHigh, dah);
    write_reg(uhcg_pkg::CfgDstAddrLow, dal);
    write_reg(uhcg_pkg::CfgSrcPort, sp);
    write_reg(uhcg_pkg::CfgDstPort, dp);
    cfg_valid_i <= 1'b0;
  endtask

  // Register value leaning on the extremes: zero, all ones, or random.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 3))
      0: return 64'd0;
      1: return {64{1'b1}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_random_config();
    write_config(pick_value(), pick_value(), pick_value(), pick_value(),
                 pick_value(), pick_value());
  endtask

  // Header sink. For every header word it draws a stall length, holds stall
  // for that many cycles, then takes the next word and checks it. A pending
  // long hold request replaces the draw once.
  initial begin : header_sink
    int unsigned hold;
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        hold = 300;
        long_hold_req = 1'b0;
      end else begin
        hold = recv_quiet ? 0 : $urandom_range(0, 8);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_header(hdr_src_port_o, hdr_dst_port_o, hdr_length_o,
                      hdr_checksum_o, too_long_o);
    end
  end

  // Main sequence: directed packets under the reset and the all-ones
  // configuration, then random phases with a fresh configuration each.
  initial begin : stimulus
    int unsigned phase;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty packet: a last word with no bytes still yields a header.
    push_word(16'hFFFF, 2'd0, 1'b1);
    // With all registers zero this payload makes the sum all ones, so the
    // checksum comes out as zero and must not be remapped.
    push_word(16'hFFDA, 2'd2, 1'b1);
    // Single-byte last word: the low byte is masked.
    push_word(16'hFFFF, 2'd1, 1'b1);
    // Single byte in mid-packet, with no realignment of later words.
    push_word(16'hABCD, 2'd1, 1'b0);
    push_word(16'h1234, 2'd2, 1'b0);
    push_word(16'hFFFF, 2'd2, 1'b1);
    // A count of three acts as two; a count of zero adds nothing.
    push_word(16'hFFFF, 2'd3, 1'b0);
    push_word(16'hFFFF, 2'd0, 1'b0);
    push_word(16'h0000, 2'd3, 1'b1);
    // Repeated end-around carries.
    push_word(16'hFFFF, 2'd2, 1'b0);
    push_word(16'hFFFF, 2'd2, 1'b0);
    push_word(16'hFFFF, 2'd2, 1'b1);
    drain();

    write_config({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                 {64{1'b1}}, {64{1'b1}});
    push_word(16'h0000, 2'd2, 1'b1);
    push_word(16'hFFFF, 2'd1, 1'b1);
    push_word(16'h8001, 2'd0, 1'b1);
    push_word(16'h7FFE, 2'd2, 1'b0);
    push_word(16'h0001, 2'd1, 1'b1);
    drain();

    // Random phases until enough words and headers have gone through.
    phase = 0;
    while (rand_items < 1000 || sb.hdr_count < 48) begin
      write_random_config();
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // Back-pressure phase: the sink holds off while words keep coming.
        send_quiet    = 1'b1;
        recv_quiet    = 1'b0;
        long_hold_req = 1'b1;
      end
      repeat (25) send_rand_packet();
      drain();
      phase++;
    end

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
